FILE: hdl/pue_pkg.sv
// Shared constants, types and codes for the polygon unique edge extractor.
package pue_pkg;

	localparam int VERTEX_BITS = 16;
	localparam int MAX_CORNERS = 16;
	localparam int TABLE_DEPTH = 4096;

	localparam int OUT_BITS = 16;
	localparam int KEY_BITS = 2 * VERTEX_BITS;
	localparam int SLOT_BITS = KEY_BITS + 1;
	localparam int IDX_BITS = $clog2(TABLE_DEPTH);
	localparam int HELD_BITS = $clog2(TABLE_DEPTH + 1);
	localparam int CNT_BITS = $clog2(MAX_CORNERS + 1);
	localparam int CIDX_BITS = $clog2(MAX_CORNERS);
	localparam int HASH_BITS = 32;
	localparam logic [HASH_BITS-1:0] HASH_MULT = 32'h9E3779B1;
	localparam bit DEPTH_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

	typedef logic [VERTEX_BITS-1:0] vtx_t;
	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [IDX_BITS-1:0] slot_idx_t;

	typedef enum logic [1:0] {
		ST_NEW = 2'd0,
		ST_SHORT = 2'd1,
		ST_LONG = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RD_LAST,
		S_PRIME,
		S_NEXT,
		S_KEY,
		S_HASH,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_FLUSH
	} state_t;

endpackage

FILE: hdl/polygon_unique_edge_extractor_unit.sv
// Top level of the polygon unique edge extractor: corner buffer, edge hash set and control.
//
// Input channel (in_valid, in_stall) carries one corner or one clear action per transaction.
// A corner is stored in the corner buffer; polygon_end on a corner closes the polygon and
// starts the edge walk, or an error result if too short or too long; in_stall stays high
// while either runs. A clear action zeroes all TABLE_DEPTH slots (4096 by default), with no result.
// Output channel (out_valid, out_stall) carries result transactions: new edges in order of
// first appearance, or one error result. run_end marks the last result of a polygon; a
// polygon whose edges are all known already gives no result.
// A closing polygon walks its edges through the two-stage hash pipeline and the registered
// reads of the corner buffer and the edge table, plus one probe step per slot collision.
// With a table size that is not a power of two, the slot reduction adds an iterative remainder
// step to each edge.
// Reset clears all control state and then runs the same table sweep before the first
// input transaction is taken. A stalled receiver holds the result register; the walk
// pauses once a second result is pending behind it.
module polygon_unique_edge_extractor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [15:0] vertex,
	input  logic        polygon_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] edge_low,
	output logic [15:0] edge_high,
	output logic [1:0]  status,
	output logic        run_end
);

	import pue_pkg::*;

	state_t                state_q;
	state_t                state_d;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  overlong_q;
	logic [CNT_BITS-1:0]   n_q;
	logic [CNT_BITS-1:0]   i_q;
	vtx_t                  prev_q;
	key_t                  key_q;
	slot_idx_t             slot_q;
	logic [HELD_BITS-1:0]  probe_q;
	logic [HELD_BITS-1:0]  held_q;
	slot_idx_t             sweep_q;
	logic                  pend_valid_q;
	vtx_t                  pend_lo_q;
	vtx_t                  pend_hi_q;
	status_t               pend_st_q;
	logic                  out_valid_q;
	logic [OUT_BITS-1:0]   out_lo_q;
	logic [OUT_BITS-1:0]   out_hi_q;
	status_t               out_st_q;
	logic                  out_end_q;

	logic                  in_take;
	logic                  out_free;
	logic                  push_ok;
	logic [CNT_BITS-1:0]   n_new;
	logic                  long_new;
	logic                  table_full;
	logic                  probe_last;
	logic                  edge_last;
	logic                  sweep_last;
	vtx_t                  cur_lo;
	vtx_t                  cur_hi;
	logic                  slot_used;
	logic                  key_match;
	logic                  chk_new;
	logic                  chk_full;
	logic                  chk_step;
	logic                  chk_res;
	logic                  chk_go;
	logic                  push;
	logic                  flush_go;

	logic                  cb_we;
	logic [CIDX_BITS-1:0]  cb_waddr;
	logic                  cb_re;
	logic [CIDX_BITS-1:0]  cb_raddr;
	vtx_t                  cb_rdata;
	logic                  tb_we;
	slot_idx_t             tb_waddr;
	logic [SLOT_BITS-1:0]  tb_wdata;
	logic                  tb_re;
	logic [SLOT_BITS-1:0]  tb_rdata;
	logic                  hash_start;
	logic                  hash_done;
	slot_idx_t             hash_idx;

	pue_ram #(
		.WIDTH(VERTEX_BITS),
		.DEPTH(MAX_CORNERS)
	) u_corner_ram (
		.clk  (clk),
		.we   (cb_we),
		.waddr(cb_waddr),
		.wdata(VERTEX_BITS'(vertex)),
		.re   (cb_re),
		.raddr(cb_raddr),
		.rdata(cb_rdata)
	);

	pue_ram #(
		.WIDTH(SLOT_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_edge_ram (
		.clk  (clk),
		.we   (tb_we),
		.waddr(tb_waddr),
		.wdata(tb_wdata),
		.re   (tb_re),
		.raddr(slot_q),
		.rdata(tb_rdata)
	);

	pue_hash u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hash_start),
		.key   ({cur_lo, cur_hi}),
		.done  (hash_done),
		.idx   (hash_idx)
	);

	assign in_take = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign push_ok = !pend_valid_q || out_free;
	assign n_new = (cnt_q < CNT_BITS'(MAX_CORNERS)) ? cnt_q + CNT_BITS'(1) : cnt_q;
	assign long_new = overlong_q || (cnt_q == CNT_BITS'(MAX_CORNERS));
	assign table_full = held_q == HELD_BITS'(TABLE_DEPTH);
	assign probe_last = probe_q == HELD_BITS'(TABLE_DEPTH - 1);
	assign edge_last = (i_q + CNT_BITS'(1)) == n_q;
	assign sweep_last = sweep_q == IDX_BITS'(TABLE_DEPTH - 1);
	assign cur_lo = (cb_rdata < prev_q) ? cb_rdata : prev_q;
	assign cur_hi = (cb_rdata < prev_q) ? prev_q : cb_rdata;
	assign slot_used = tb_rdata[KEY_BITS];
	assign key_match = tb_rdata[KEY_BITS-1:0] == key_q;
	assign chk_new = !slot_used && !table_full;
	assign chk_full = (!slot_used && table_full) || (slot_used && !key_match && probe_last);
	assign chk_step = slot_used && !key_match && !probe_last;
	assign chk_res = chk_new || chk_full;
	assign chk_go = !chk_res || push_ok;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_take) begin
					if (action) begin
						state_d = S_CLEAR;
					end else if (polygon_end) begin
						if (long_new || n_new < CNT_BITS'(3)) begin
							state_d = S_FLUSH;
						end else begin
							state_d = S_RD_LAST;
						end
					end
				end
			end
			S_RD_LAST: state_d = S_PRIME;
			S_PRIME: state_d = S_KEY;
			S_NEXT: state_d = S_KEY;
			S_KEY: state_d = S_HASH;
			S_HASH: begin
				if (hash_done) begin
					state_d = S_PROBE_RD;
				end
			end
			S_PROBE_RD: state_d = S_PROBE_CHK;
			S_PROBE_CHK: begin
				if (chk_go) begin
					if (chk_full) begin
						state_d = S_FLUSH;
					end else if (chk_step) begin
						state_d = S_PROBE_RD;
					end else if (edge_last) begin
						state_d = S_FLUSH;
					end else begin
						state_d = S_NEXT;
					end
				end
			end
			S_FLUSH: begin
				if (!pend_valid_q || out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = state_q != S_IDLE;
		cb_we = (state_q == S_IDLE) && in_take && !action
			&& (cnt_q < CNT_BITS'(MAX_CORNERS));
		cb_waddr = cnt_q[CIDX_BITS-1:0];
		cb_re = (state_q == S_RD_LAST) || (state_q == S_PRIME) || (state_q == S_NEXT);
		cb_raddr = (state_q == S_RD_LAST) ? n_q[CIDX_BITS-1:0] - CIDX_BITS'(1)
			: i_q[CIDX_BITS-1:0];
		hash_start = state_q == S_KEY;
		tb_re = state_q == S_PROBE_RD;
		push = (state_q == S_PROBE_CHK) && chk_res && chk_go;
		flush_go = (state_q == S_FLUSH) && (!pend_valid_q || out_free);
		if (state_q == S_CLEAR) begin
			tb_we = 1'b1;
			tb_waddr = sweep_q;
			tb_wdata = '0;
		end else begin
			tb_we = (state_q == S_PROBE_CHK) && chk_new && chk_go;
			tb_waddr = slot_q;
			tb_wdata = {1'b1, key_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
			overlong_q <= 1'b0;
			held_q <= '0;
			sweep_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				held_q <= '0;
				sweep_q <= sweep_last ? '0 : sweep_q + IDX_BITS'(1);
			end
			if ((state_q == S_IDLE) && in_take && !action) begin
				if (polygon_end) begin
					cnt_q <= '0;
					overlong_q <= 1'b0;
					pend_valid_q <= long_new || (n_new < CNT_BITS'(3));
				end else if (cnt_q < CNT_BITS'(MAX_CORNERS)) begin
					cnt_q <= cnt_q + CNT_BITS'(1);
				end else begin
					overlong_q <= 1'b1;
				end
			end
			if (tb_we && (state_q == S_PROBE_CHK)) begin
				held_q <= held_q + HELD_BITS'(1);
			end
			if (push) begin
				pend_valid_q <= 1'b1;
			end else if (flush_go) begin
				pend_valid_q <= 1'b0;
			end
			if ((push || flush_go) && pend_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_take && !action && polygon_end) begin
			n_q <= n_new;
			i_q <= '0;
			pend_lo_q <= '0;
			pend_hi_q <= '0;
			pend_st_q <= long_new ? ST_LONG : ST_SHORT;
		end
		if (state_q == S_PRIME) begin
			prev_q <= cb_rdata;
		end
		if (state_q == S_KEY) begin
			prev_q <= cb_rdata;
			key_q <= {cur_lo, cur_hi};
		end
		if ((state_q == S_HASH) && hash_done) begin
			slot_q <= hash_idx;
			probe_q <= '0;
		end
		if ((state_q == S_PROBE_CHK) && chk_step) begin
			slot_q <= (slot_q == IDX_BITS'(TABLE_DEPTH - 1)) ? '0 : slot_q + IDX_BITS'(1);
			probe_q <= probe_q + HELD_BITS'(1);
		end
		if ((state_q == S_PROBE_CHK) && chk_go && !chk_step && !chk_full && !edge_last) begin
			i_q <= i_q + CNT_BITS'(1);
		end
		if (push) begin
			pend_lo_q <= key_q[KEY_BITS-1:VERTEX_BITS];
			pend_hi_q <= key_q[VERTEX_BITS-1:0];
			pend_st_q <= chk_full ? ST_FULL : ST_NEW;
		end
		if ((push || flush_go) && pend_valid_q) begin
			out_lo_q <= OUT_BITS'(pend_lo_q);
			out_hi_q <= OUT_BITS'(pend_hi_q);
			out_st_q <= pend_st_q;
			out_end_q <= flush_go;
		end
	end

	assign out_valid = out_valid_q;
	assign edge_low = out_lo_q;
	assign edge_high = out_hi_q;
	assign status = out_st_q;
	assign run_end = out_end_q;

endmodule

FILE: hdl/pue_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pue_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/pue_hash.sv
// Edge key hash: fold, multiply, mix and reduce to a table slot index.
module pue_hash (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  pue_pkg::key_t      key,
	output logic               done,
	output pue_pkg::slot_idx_t idx
);

	import pue_pkg::*;

	localparam int MOD_STEP = 4;
	localparam int MOD_ITERS = HASH_BITS / MOD_STEP;
	localparam int ITER_BITS = $clog2(MOD_ITERS);
	localparam logic [IDX_BITS:0] DEPTH_WIDE = (IDX_BITS + 1)'(TABLE_DEPTH);

	logic [63:0]          key_wide;
	logic [HASH_BITS-1:0] fold;
	logic [HASH_BITS-1:0] mix_s1;
	logic [HASH_BITS-1:0] prod_s2;
	logic [HASH_BITS-1:0] mixed;
	logic                 valid_s1;
	logic                 valid_s2;
	logic [HASH_BITS-1:0] h_q;
	slot_idx_t            rem_q;
	slot_idx_t            rem_next;
	slot_idx_t            r;
	logic [IDX_BITS:0]    t;
	logic [ITER_BITS-1:0] iter_q;
	logic                 busy_q;
	logic                 done_q;

	assign key_wide = 64'(key);
	assign fold = HASH_BITS'(key_wide ^ (key_wide >> 29));
	assign mixed = prod_s2 ^ (prod_s2 >> 15);

	always_comb begin
		r = rem_q;
		t = '0;
		for (int k = 0; k < MOD_STEP; k++) begin
			t = {r, h_q[HASH_BITS-1-k]};
			if (t >= DEPTH_WIDE) begin
				t = t - DEPTH_WIDE;
			end
			r = t[IDX_BITS-1:0];
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			done_q <= 1'b0;
			if (valid_s2 && !DEPTH_POW2) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + ITER_BITS'(1);
				if (iter_q == ITER_BITS'(MOD_ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mix_s1 <= fold;
		end
		if (valid_s1) begin
			prod_s2 <= mix_s1 * HASH_MULT;
		end
		if (valid_s2) begin
			h_q <= mixed;
			rem_q <= '0;
		end else if (busy_q) begin
			h_q <= h_q << MOD_STEP;
			rem_q <= rem_next;
		end
	end

	always_comb begin
		if (DEPTH_POW2) begin
			done = valid_s2;
			idx = mixed[IDX_BITS-1:0];
		end else begin
			done = done_q;
			idx = rem_q;
		end
	end

endmodule
